### rtl/lcar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcar_pkg;

    // Fixed field widths
    localparam int MAX_CH      = 4;
    localparam int DATA_BITS   = 24;
    localparam int BIT_CNT_W   = $clog2(DATA_BITS + 1);
    localparam int CHANNELS_DEF = 4;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // Register indexes
    localparam logic CFG_ACTIVE_MASK = 1'b0;
    localparam logic CFG_GAIN_MODE   = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_CLOCK    = 3'd0;
    localparam logic [2:0] ST_VALUE    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_BAD_GAIN = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    // Request kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  dout_levels;
        logic [15:0] wait_limit;
    } in_item_t;

    typedef struct packed {
        logic                         sck_level;
        logic [2:0]                   status;
        logic [1:0]                   channel;
        logic signed [DATA_BITS-1:0]  sample_value;
        logic                         last;
    } out_item_t;

    // One job handed from the sequencer to the result unit
    typedef struct packed {
        logic                                 is_values;
        logic                                 sck_level;
        logic [2:0]                           status;
        logic                                 last;
        logic [MAX_CH-1:0]                    mask;
        logic [MAX_CH-1:0][DATA_BITS-1:0]     vals;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_req_t;

endpackage

`default_nettype wire

### rtl/lcar_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcar_front #(
    parameter int CHANNELS = lcar_pkg::CHANNELS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire lcar_pkg::in_item_t item,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [3:0]        cfg_data,
    output lcar_pkg::job_req_t     push
);
    import lcar_pkg::*;

    localparam int NUM_LANES = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
    localparam logic [MAX_CH-1:0] EN_MASK = MAX_CH'((1 << NUM_LANES) - 1);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_SHIFT = 2'd2;
    localparam logic [1:0] PH_PULSE = 2'd3;

    logic [3:0]                          active_mask_reg;
    logic [1:0]                          gain_mode_reg;
    logic [1:0]                          phase_reg, phase_next;
    logic [15:0]                         wait_count_reg, wait_count_next;
    logic [BIT_CNT_W-1:0]                bit_count_reg, bit_count_next;
    logic [1:0]                          pulse_count_reg, pulse_count_next;
    logic                                clock_high_reg, clock_high_next;
    logic [NUM_LANES-1:0][DATA_BITS-1:0] shift_reg, shift_next;
    logic [MAX_CH-1:0][DATA_BITS-1:0]    snap;

    logic [MAX_CH-1:0]    m;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic [1:0]           pulse_inc;
    logic [1:0]           pulses;

    function automatic job_t single(input logic sck, input logic [2:0] st, input logic lst);
        job_t j;
        j           = '0;
        j.sck_level = sck;
        j.status    = st;
        j.last      = lst;
        return j;
    endfunction

    genvar g;
    generate
        for (g = 0; g < MAX_CH; g++) begin : g_snap
            if (g < NUM_LANES) begin : g_lane
                assign snap[g] = shift_reg[g];
            end else begin : g_pad
                assign snap[g] = '0;
            end
        end
    endgenerate

    assign m         = active_mask_reg & EN_MASK;
    assign bit_inc   = bit_count_reg + BIT_CNT_W'(1);
    assign pulse_inc = pulse_count_reg + 2'd1;
    assign pulses    = (gain_mode_reg <= 2'd2) ? gain_mode_reg + 2'd1 : 2'd0;

    always_comb
    begin
        phase_next       = phase_reg;
        wait_count_next  = wait_count_reg;
        bit_count_next   = bit_count_reg;
        pulse_count_next = pulse_count_reg;
        clock_high_next  = clock_high_reg;
        shift_next       = shift_reg;
        push             = '0;
        if (accept)
        begin
            if (item.kind == KIND_READ)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (m == '0)
                    begin
                        push.valid = 1'b1;
                        push.job   = single(1'b0, ST_NONE, 1'b1);
                    end
                    else
                    begin
                        phase_next       = PH_WAIT;
                        wait_count_next  = item.wait_limit;
                        bit_count_next   = '0;
                        pulse_count_next = '0;
                        clock_high_next  = 1'b0;
                        shift_next       = '0;
                    end
                end
            end
            else
            begin
                push.valid = 1'b1;
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if ((item.dout_levels & m) == '0)
                        begin
                            phase_next      = PH_SHIFT;
                            clock_high_next = 1'b1;
                            push.job        = single(1'b1, ST_CLOCK, 1'b0);
                        end
                        else if (wait_count_reg == '0)
                        begin
                            phase_next      = PH_IDLE;
                            clock_high_next = 1'b0;
                            push.job        = single(1'b0, ST_TIMEOUT, 1'b1);
                        end
                        else
                        begin
                            wait_count_next = wait_count_reg - 16'd1;
                            push.job        = single(1'b0, ST_CLOCK, 1'b0);
                        end
                    end
                    PH_SHIFT:
                    begin
                        if (!clock_high_reg)
                        begin
                            clock_high_next = 1'b1;
                            push.job        = single(1'b1, ST_CLOCK, 1'b0);
                        end
                        else
                        begin
                            for (int i = 0; i < NUM_LANES; i++)
                            begin
                                if (m[i])
                                    shift_next[i] = {shift_reg[i][DATA_BITS-2:0],
                                                     item.dout_levels[i]};
                            end
                            clock_high_next = 1'b0;
                            bit_count_next  = bit_inc;
                            push.job        = single(1'b0, ST_CLOCK, 1'b0);
                            if (bit_inc >= BIT_CNT_W'(DATA_BITS))
                            begin
                                if (pulses == 2'd0)
                                begin
                                    phase_next = PH_IDLE;
                                    push.job   = single(1'b0, ST_BAD_GAIN, 1'b1);
                                end
                                else
                                begin
                                    phase_next       = PH_PULSE;
                                    pulse_count_next = '0;
                                end
                            end
                        end
                    end
                    PH_PULSE:
                    begin
                        if (!clock_high_reg)
                        begin
                            clock_high_next = 1'b1;
                            push.job        = single(1'b1, ST_CLOCK, 1'b0);
                        end
                        else
                        begin
                            clock_high_next  = 1'b0;
                            pulse_count_next = pulse_inc;
                            if (pulse_inc >= pulses)
                            begin
                                phase_next = PH_IDLE;
                                if (m == '0)
                                    push.job = single(1'b0, ST_NONE, 1'b1);
                                else
                                begin
                                    push.job           = single(1'b0, ST_VALUE, 1'b0);
                                    push.job.is_values = 1'b1;
                                    push.job.mask      = m;
                                    push.job.vals      = snap;
                                end
                            end
                            else
                                push.job = single(1'b0, ST_CLOCK, 1'b0);
                        end
                    end
                    default:
                    begin
                        // idle tick: clock stays low
                        phase_next      = PH_IDLE;
                        clock_high_next = 1'b0;
                        push.job        = single(1'b0, ST_CLOCK, 1'b0);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mask_reg <= 4'd1;
            gain_mode_reg   <= 2'd0;
            phase_reg       <= PH_IDLE;
            wait_count_reg  <= '0;
            bit_count_reg   <= '0;
            pulse_count_reg <= '0;
            clock_high_reg  <= 1'b0;
            shift_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACTIVE_MASK: active_mask_reg <= cfg_data;
                    CFG_GAIN_MODE:   gain_mode_reg   <= cfg_data[1:0];
                    default:         ;
                endcase
            end
            phase_reg       <= phase_next;
            wait_count_reg  <= wait_count_next;
            bit_count_reg   <= bit_count_next;
            pulse_count_reg <= pulse_count_next;
            clock_high_reg  <= clock_high_next;
            shift_reg       <= shift_next;
        end
    end

endmodule

`default_nettype wire

### rtl/lcar_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lcar_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lcar_pkg::job_req_t push,
    input  wire logic               pop,
    output logic                    full,
    output lcar_pkg::job_req_t      head
);
    import lcar_pkg::*;

    job_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + Q_CNT_W'(push.valid) - Q_CNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/lcar_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcar_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lcar_pkg::job_req_t head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output lcar_pkg::out_item_t     out_data
);
    import lcar_pkg::*;

    logic      cur_valid_reg, cur_valid_next;
    job_t      cur_reg, cur_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic              can_out, emit, done, cur_free;
    logic [1:0]        idx;
    logic [MAX_CH-1:0] rem;

    // lowest remaining channel
    always_comb
    begin
        idx = '0;
        for (int i = MAX_CH - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
                idx = 2'(i);
        end
    end

    assign rem      = cur_reg.mask & ~(MAX_CH'(1) << idx);
    assign can_out  = !out_valid_reg || !out_stall;
    assign emit     = cur_valid_reg && can_out;
    assign done     = !cur_reg.is_values || (rem == '0);
    assign cur_free = !cur_valid_reg || (emit && done);
    assign pop      = cur_free && head.valid;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (cur_reg.is_values)
            begin
                out_next.sck_level    = 1'b0;
                out_next.status       = ST_VALUE;
                out_next.channel      = idx;
                out_next.sample_value = $signed(cur_reg.vals[idx]);
                out_next.last         = (rem == '0);
                cur_next.mask         = rem;
            end
            else
            begin
                out_next.sck_level    = cur_reg.sck_level;
                out_next.status       = cur_reg.status;
                out_next.channel      = '0;
                out_next.sample_value = '0;
                out_next.last         = cur_reg.last;
            end
        end
        if (cur_free)
        begin
            cur_valid_next = head.valid;
            cur_next       = head.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### rtl/load_cell_adc_multichannel_reader_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_data  (kind, dout_levels, wait_limit)
// out       output     out_valid / out_stall out_data (sck_level, status, channel,
//                                                      sample_value, last)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// Each accepted request is handled by the sequencer; its result reaches the output
// register through the job queue slot, the result unit and the output stage.
// A value read turns one tick into up to four results, drained one per cycle while
// out_stall is low, so the input stalls while the two-entry job queue is full.
// Reset: sequencer idle, active_mask 1, gain_mode 0, queue empty, no result valid.
// in_stall follows the queue full flag; out_stall holds the output and backs up.
module load_cell_adc_multichannel_reader_core #(
    parameter int CHANNELS = lcar_pkg::CHANNELS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire lcar_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output lcar_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [3:0]          cfg_data
);
    import lcar_pkg::*;

    job_req_t push;
    job_req_t head;
    logic     q_full;
    logic     pop;
    logic     in_accept;

    // Front takes a request whenever a job slot is free
    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    // Sequencer: wait, shift and gain-pulse phases, config registers
    lcar_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .item      (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    // Short job queue between sequencer and result unit
    lcar_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // Result unit: expands value jobs to one result per enabled channel
    lcar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
